### rtl/http_status_and_length_prefixed_deframer_assert.svh
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clock and reset in the using module.
`ifndef HTTP_STATUS_AND_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define HTTP_STATUS_AND_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

// Checked only outside reset.
`define HSD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define HSD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/hsd_pkg.sv
// Types and constants for the HTTP status and length-prefixed deframer.
// No dependencies; imported by every deframer module.
package hsd_pkg;

   typedef enum logic [7:0] {
      PH_PREFIX  = 8'b0000_0001,
      PH_VERSION = 8'b0000_0010,
      PH_STATUS  = 8'b0000_0100,
      PH_HEADER  = 8'b0000_1000,
      PH_SPACERS = 8'b0001_0000,
      PH_LENGTH  = 8'b0010_0000,
      PH_PAYLOAD = 8'b0100_0000,
      PH_TERM    = 8'b1000_0000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_END     = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_PREFIX   = 2'd0,
      ERR_DIGIT    = 2'd1,
      ERR_OVERFLOW = 2'd2,
      ERR_TERM     = 2'd3
   } err_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         data;
      logic signed [15:0] status;
      err_type            err;
      logic               last;
   } result_type;

   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   localparam logic [7:0]  CHAR_CR    = 8'h0D;
   localparam logic [7:0]  CHAR_LF    = 8'h0A;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_NINE  = 8'h39;
   localparam logic [2:0]  PREFIX_LAST = 3'd4;
   localparam logic [1:0]  STATUS_DIGITS = 2'd3;
   localparam logic [1:0]  HEADER_END_LAST = 2'd3;

   // Characters of the protocol prefix "HTTP/".
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h48;
         3'd1:    ch = 8'h54;
         3'd2:    ch = 8'h54;
         3'd3:    ch = 8'h50;
         3'd4:    ch = 8'h2F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### rtl/hsd_parse.sv
// Input word register and parser state for the deframer.
// Depends on hsd_pkg and the deframer assertion macros.
`include "http_status_and_length_prefixed_deframer_assert.svh"

module hsd_parse #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   input  logic                 out_ready,
   output logic                 push,
   output hsd_pkg::result_type  push_result
);
   import hsd_pkg::*;

   localparam int PW = LENGTH_BITS + 4;

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   advance, accept;

   phase_type              phase_ff, phase_in;
   logic [2:0]             prefix_index_ff, prefix_index_in;
   logic [15:0]            status_accum_ff, status_accum_in;
   logic [1:0]             status_count_ff, status_count_in;
   logic [1:0]             match_ff, match_in;
   logic [LENGTH_BITS-1:0] length_accum_ff, length_accum_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;

   logic                   has_result;
   result_type             result;
   logic [7:0]             b;
   logic [LENGTH_BITS-1:0] len_src;
   logic [PW-1:0]          len_wide;
   logic [PW-1:0]          len_next;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic [7:0]             hdr_expect;

   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   assign b = in_byte_ff;
   // A length line entered from the spacer phase starts from zero.
   assign len_src  = (phase_ff == PH_SPACERS) ? '0 : length_accum_ff;
   assign len_wide = {4'b0000, len_src};
   assign len_next = (len_wide << 3) + (len_wide << 1)
                   + {{(PW-4){1'b0}}, 4'(b - CHAR_ZERO)};
   assign rem_dec  = remaining_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
   assign hdr_expect = match_ff[0] ? CHAR_LF : CHAR_CR;

   always_comb begin
      phase_in        = phase_ff;
      prefix_index_in = prefix_index_ff;
      status_accum_in = status_accum_ff;
      status_count_in = status_count_ff;
      match_in        = match_ff;
      length_accum_in = length_accum_ff;
      remaining_in    = remaining_ff;
      has_result      = 1'b0;
      result          = '0;

      unique case (phase_ff)
         PH_PREFIX: begin
            if (prefix_index_ff > PREFIX_LAST || b != prefix_char(prefix_index_ff)) begin
               has_result  = 1'b1;
               result.kind = KIND_ERROR;
               result.err  = ERR_PREFIX;
            end else if (prefix_index_ff == PREFIX_LAST) begin
               prefix_index_in = '0;
               phase_in        = PH_VERSION;
            end else begin
               prefix_index_in = prefix_index_ff + 3'd1;
            end
         end
         PH_VERSION: begin
            if (b == CHAR_SPACE) begin
               status_accum_in = '0;
               status_count_in = '0;
               phase_in        = PH_STATUS;
            end
         end
         PH_STATUS: begin
            // No digit check: any byte is folded in, modulo 2^16.
            status_accum_in = (status_accum_ff << 3) + (status_accum_ff << 1)
                            + {8'h00, b} - {8'h00, CHAR_ZERO};
            if (status_count_ff == STATUS_DIGITS - 2'd1) begin
               status_count_in = '0;
               match_in        = '0;
               phase_in        = PH_HEADER;
            end else begin
               status_count_in = status_count_ff + 2'd1;
            end
         end
         PH_HEADER: begin
            if (b == hdr_expect) begin
               if (match_ff == HEADER_END_LAST) begin
                  match_in      = '0;
                  phase_in      = PH_SPACERS;
                  has_result    = 1'b1;
                  result.kind   = KIND_STATUS;
                  result.status = status_accum_ff;
               end else begin
                  match_in = match_ff + 2'd1;
               end
            end else begin
               match_in = (b == CHAR_CR) ? 2'd1 : 2'd0;
            end
         end
         PH_SPACERS, PH_LENGTH: begin
            if (phase_ff == PH_SPACERS && b == CHAR_SPACE) begin
               phase_in = PH_SPACERS;
            end else if (b == CHAR_LF) begin
               remaining_in    = len_src;
               length_accum_in = '0;
               phase_in        = (len_src == '0) ? PH_TERM : PH_PAYLOAD;
            end else if (b < CHAR_ZERO || b > CHAR_NINE) begin
               has_result  = 1'b1;
               result.kind = KIND_ERROR;
               result.err  = ERR_DIGIT;
            end else if (len_next[PW-1:LENGTH_BITS] != 4'b0000) begin
               has_result  = 1'b1;
               result.kind = KIND_ERROR;
               result.err  = ERR_OVERFLOW;
            end else begin
               length_accum_in = len_next[LENGTH_BITS-1:0];
               phase_in        = PH_LENGTH;
            end
         end
         PH_PAYLOAD: begin
            remaining_in = rem_dec;
            if (rem_dec == '0) begin
               phase_in = PH_TERM;
            end
            has_result  = 1'b1;
            result.kind = KIND_PAYLOAD;
            result.data = b;
         end
         PH_TERM: begin
            has_result = 1'b1;
            if (b != CHAR_LF) begin
               result.kind = KIND_ERROR;
               result.err  = ERR_TERM;
            end else begin
               phase_in    = PH_SPACERS;
               result.kind = KIND_END;
               result.last = 1'b1;
            end
         end
         default: begin
            phase_in = PH_PREFIX;
         end
      endcase

      // Every error puts the whole parser back to its reset state.
      if (has_result && result.kind == KIND_ERROR) begin
         phase_in        = PH_PREFIX;
         prefix_index_in = '0;
         status_accum_in = '0;
         status_count_in = '0;
         match_in        = '0;
         length_accum_in = '0;
         remaining_in    = '0;
      end
   end

   assign push        = advance && has_result;
   assign push_result = result;

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         phase_ff        <= PH_PREFIX;
         prefix_index_ff <= '0;
         status_accum_ff <= '0;
         status_count_ff <= '0;
         match_ff        <= '0;
         length_accum_ff <= '0;
         remaining_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff        <= phase_in;
            prefix_index_ff <= prefix_index_in;
            status_accum_ff <= status_accum_in;
            status_count_ff <= status_count_in;
            match_ff        <= match_in;
            length_accum_ff <= length_accum_in;
            remaining_ff    <= remaining_in;
         end
      end
   end

   `HSD_ASSERT(prefix_index_in_range, prefix_index_ff <= PREFIX_LAST, "prefix index past prefix")
   `HSD_ASSERT(match_only_in_header, phase_ff != PH_HEADER |-> match_ff == 2'd0, "stale match")
   `HSD_ASSERT(payload_never_empty, phase_ff == PH_PAYLOAD |-> remaining_ff != '0, "empty payload")
   `HSD_ASSERT(count_only_in_status, phase_ff != PH_STATUS |-> status_count_ff == 2'd0, "stale count")

endmodule

### rtl/hsd_outreg.sv
// Result register of the deframer: holds one result word until taken.
// Depends on hsd_pkg and the deframer assertion macros.
`include "http_status_and_length_prefixed_deframer_assert.svh"

module hsd_outreg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hsd_pkg::result_type  push_result,
   output logic                 out_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hsd_pkg::result_type  rsp_result
);
   import hsd_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign out_ready  = !valid_ff || !rsp_stall;
   assign valid_in   = push ? 1'b1 : (valid_ff && rsp_stall);
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         result_ff <= push_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   `HSD_ASSERT(no_overwrite, push |-> out_ready, "result word overwritten while stalled")
   `HSD_ASSERT(last_marks_end, valid_ff |-> (result_ff.last == (result_ff.kind == KIND_END)), "last flag disagrees with kind")
   `HSD_ASSERT_ALWAYS(empty_after_reset, reset |=> !valid_ff, "result valid after reset")

endmodule

### rtl/http_status_and_length_prefixed_deframer.sv
// Each accepted byte is registered; its result word, if any, then in the output register.
// Throughput: one byte per cycle while rsp_stall is low; under stall the input
// register takes one more byte while a result word waits in the output register.
// Each byte is handled by one pass of the parser between those two registers.
// Synchronous active-high reset returns the parser to the "HTTP/" prefix and
// empties both registers.
module http_status_and_length_prefixed_deframer #(
   parameter int LENGTH_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_out_kind,
   output logic [7:0]         rsp_out_byte,
   output logic signed [15:0] rsp_status_code,
   output logic [1:0]         rsp_error_code,
   output logic               rsp_last
);
   import hsd_pkg::*;

   logic       out_ready;
   logic       push;
   result_type push_result;
   result_type rsp_result;

   hsd_parse #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .out_ready   (out_ready),
      .push        (push),
      .push_result (push_result)
   );

   hsd_outreg u_outreg (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_result (push_result),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result)
   );

   assign rsp_out_kind    = rsp_result.kind;
   assign rsp_out_byte    = rsp_result.data;
   assign rsp_status_code = rsp_result.status;
   assign rsp_error_code  = rsp_result.err;
   assign rsp_last        = rsp_result.last;

endmodule
